FILE: rtl/vlbs_pkg.sv
// vlbs_pkg: shared types, codes and defaults of the variable length byte stack
// used by the top level, the serial unit, the checker and the bench
package vlbs_pkg;

	localparam int STORE_BYTES_DEF     = 16384;
	localparam int MAX_ENTRY_BYTES_DEF = 32;
	localparam int MAX_ENTRIES_DEF     = 1024;

	localparam int CMD_W   = 3;
	localparam int LEN_W   = 6;
	localparam int DEPTH_W = 11;
	localparam int INT_W   = 28;

	localparam logic [CMD_W-1:0] CMD_PUSH     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP      = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_BYTE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_PEEK     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_POP_INT  = 3'd4;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_EMPTY    = 2'd1;
	localparam logic [1:0] STATUS_NOT_BYTE = 2'd2;

	localparam logic [INT_W-1:0] SAT_INT = 28'hFFFFFFF;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [7:0]         data_byte;
		logic               last;
		logic [LEN_W-1:0]   req_len;
		logic [DEPTH_W-1:0] depth;
	} vlbs_in_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [7:0]       out_byte;
		logic [LEN_W-1:0] entry_len;
		logic [INT_W-1:0] int_value;
		logic             last_out;
	} vlbs_out_t;

	// one byte slot of a serial read stream
	typedef struct packed {
		logic             valid;
		logic             last;
		logic             pad;
		logic [CMD_W-1:0] cmd;
	} vlbs_beat_t;

endpackage

FILE: rtl/variable_length_byte_stack_unit.sv
// variable_length_byte_stack_unit: top level, command sequencer, stack pointers
// and byte store. uses vlbs_pkg, vlbs_ram, vlbs_serial
// push byte: staged, no result; push last: the commit state writes the length byte and answers
// pop: length read in the walk state, then bytes streamed one per cycle; peek walks the
//   stack one level at a time before it streams
// empty or bad depth: result in the cycle after accept; zero-length pop: answered from the walk state
// reset clears pointers, entry count and sequencer; store contents stay undefined
module variable_length_byte_stack_unit import vlbs_pkg::*; #(
	parameter int STORE_BYTES     = STORE_BYTES_DEF,
	parameter int MAX_ENTRY_BYTES = MAX_ENTRY_BYTES_DEF,
	parameter int MAX_ENTRIES     = MAX_ENTRIES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  vlbs_in_t  item,
	output logic      busy,
	output vlbs_out_t result,
	output logic      result_strobe
);

	localparam int AW = $clog2(STORE_BYTES);
	localparam int PW = $clog2(STORE_BYTES + 1);
	localparam int EW = PW + 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int DW = (CW > DEPTH_W) ? CW : DEPTH_W;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_ENTRY_BYTES);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_COMMIT = 2'd1;
	localparam logic [1:0] S_WALK   = 2'd2;
	localparam logic [1:0] S_STREAM = 2'd3;

	logic [1:0]         state_q;
	logic [PW-1:0]      fill_q;
	logic [CW-1:0]      count_q;
	logic [LEN_W-1:0]   staged_q;
	logic               commit_ok_q;
	logic [LEN_W-1:0]   commit_len_q;
	logic [CMD_W-1:0]   cmd_q;
	logic [LEN_W-1:0]   req_q;
	logic [DEPTH_W-1:0] steps_q;
	logic [PW-1:0]      p_q;
	logic [LEN_W-1:0]   len_q;
	logic [AW-1:0]      addr_q;
	logic [LEN_W-1:0]   remain_q;
	logic [LEN_W-1:0]   pad_q;
	vlbs_beat_t         beat_s1;

	logic               accept;
	logic [EW-1:0]      stage_idx;
	logic               stage_wr;
	logic [LEN_W-1:0]   staged_inc;
	logic               commit_fit;
	logic [7:0]         rd_byte;
	logic [LEN_W-1:0]   len_sat;
	logic [PW-1:0]      p_new;
	logic [LEN_W-1:0]   req_sat;
	logic               depth_bad;
	logic               walk_last;
	logic [AW-1:0]      raddr;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [7:0]         wdata;
	logic               dir_valid;
	vlbs_out_t          dir;
	vlbs_beat_t         beat_c;

	assign busy   = (state_q != S_IDLE) || beat_s1.valid;
	assign accept = start && !busy;

	always_comb begin
		stage_idx  = EW'(fill_q) + EW'(staged_q);
		stage_wr   = (staged_q < MAX_LEN) && (stage_idx < EW'(STORE_BYTES));
		staged_inc = (staged_q <= MAX_LEN) ? staged_q + LEN_W'(1) : staged_q;
		commit_fit = (staged_inc <= MAX_LEN) && (count_q < CW'(MAX_ENTRIES)) &&
			(EW'(fill_q) + EW'(staged_inc) + EW'(1) <= EW'(STORE_BYTES));
		len_sat    = (rd_byte > 8'(MAX_ENTRY_BYTES)) ? MAX_LEN : rd_byte[LEN_W-1:0];
		p_new      = p_q - PW'(rd_byte) - PW'(1);
		req_sat    = (req_q > MAX_LEN) ? MAX_LEN : req_q;
		depth_bad  = (item.depth == '0) || (DW'(item.depth) > DW'(count_q));
		walk_last  = (steps_q == DEPTH_W'(1));
	end

	always_comb begin
		case (state_q)
			S_WALK:   raddr = AW'(p_new - PW'(1));
			S_STREAM: raddr = addr_q;
			default:  raddr = AW'(fill_q - PW'(1));
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = AW'(stage_idx);
		wdata = item.data_byte;
		if ((state_q == S_IDLE) && accept && (item.cmd == CMD_PUSH) && stage_wr) begin
			we = 1'b1;
		end else if ((state_q == S_COMMIT) && commit_ok_q) begin
			we    = 1'b1;
			waddr = AW'(fill_q + PW'(commit_len_q));
			wdata = 8'(commit_len_q);
		end
	end

	always_comb begin
		dir_valid    = 1'b0;
		dir          = '0;
		dir.last_out = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (item.cmd)
						CMD_POP, CMD_POP_BYTE, CMD_POP_INT: begin
							if (count_q == '0) begin
								dir_valid  = 1'b1;
								dir.status = STATUS_EMPTY;
							end
						end
						CMD_PEEK: begin
							if (depth_bad) begin
								dir_valid  = 1'b1;
								dir.status = STATUS_EMPTY;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_COMMIT: begin
				dir_valid     = 1'b1;
				dir.status    = commit_ok_q ? STATUS_OK : STATUS_EMPTY;
				dir.entry_len = commit_ok_q ? commit_len_q : '0;
			end
			S_WALK: begin
				if (walk_last) begin
					dir.entry_len = len_sat;
					case (cmd_q)
						CMD_POP: dir_valid = (req_sat == '0);
						CMD_POP_BYTE: begin
							dir_valid  = (len_sat == '0);
							dir.status = STATUS_NOT_BYTE;
						end
						default: dir_valid = (len_sat == '0);
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		beat_c.valid = (state_q == S_STREAM);
		beat_c.last  = (remain_q == LEN_W'(1));
		beat_c.pad   = (pad_q != '0);
		beat_c.cmd   = cmd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			count_q      <= '0;
			staged_q     <= '0;
			beat_s1      <= '0;
			commit_ok_q  <= 1'b0;
			commit_len_q <= '0;
			cmd_q        <= CMD_PUSH;
			req_q        <= '0;
			steps_q      <= '0;
			p_q          <= '0;
			len_q        <= '0;
			addr_q       <= '0;
			remain_q     <= '0;
			pad_q        <= '0;
		end else begin
			beat_s1 <= beat_c;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (item.cmd)
							CMD_PUSH: begin
								staged_q <= staged_inc;
								if (item.last) begin
									staged_q     <= '0;
									commit_ok_q  <= commit_fit;
									commit_len_q <= staged_inc;
									state_q      <= S_COMMIT;
								end
							end
							CMD_POP, CMD_POP_BYTE, CMD_POP_INT: begin
								staged_q <= '0;
								cmd_q    <= item.cmd;
								req_q    <= item.req_len;
								if (count_q != '0) begin
									p_q     <= fill_q;
									steps_q <= DEPTH_W'(1);
									state_q <= S_WALK;
								end
							end
							CMD_PEEK: begin
								staged_q <= '0;
								cmd_q    <= item.cmd;
								if (!depth_bad) begin
									p_q     <= fill_q;
									steps_q <= item.depth;
									state_q <= S_WALK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_COMMIT: begin
					if (commit_ok_q) begin
						fill_q  <= fill_q + PW'(commit_len_q) + PW'(1);
						count_q <= count_q + CW'(1);
					end
					state_q <= S_IDLE;
				end
				S_WALK: begin
					if (walk_last) begin
						len_q <= len_sat;
						if (cmd_q != CMD_PEEK) begin
							fill_q  <= p_new;
							count_q <= count_q - CW'(1);
						end
						if (cmd_q == CMD_POP) begin
							remain_q <= req_sat;
							addr_q   <= AW'(p_new) + AW'(len_sat) - AW'(req_sat);
							pad_q    <= (req_sat > len_sat) ? req_sat - len_sat : '0;
						end else begin
							remain_q <= len_sat;
							addr_q   <= AW'(p_new);
							pad_q    <= '0;
						end
						state_q <= dir_valid ? S_IDLE : S_STREAM;
					end else begin
						p_q     <= p_new;
						steps_q <= steps_q - DEPTH_W'(1);
					end
				end
				S_STREAM: begin
					addr_q   <= addr_q + AW'(1);
					remain_q <= remain_q - LEN_W'(1);
					if (pad_q != '0) begin
						pad_q <= pad_q - LEN_W'(1);
					end
					if (remain_q == LEN_W'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	vlbs_ram #(
		.DEPTH (STORE_BYTES),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd_byte)
	);

	vlbs_serial u_serial (
		.clk           (clk),
		.arst_n        (arst_n),
		.beat          (beat_s1),
		.rd_byte       (rd_byte),
		.entry_len     (len_q),
		.dir_valid     (dir_valid),
		.dir           (dir),
		.result        (result),
		.result_strobe (result_strobe)
	);

endmodule

FILE: rtl/vlbs_ram.sv
// vlbs_ram: byte store, one write port and one registered read port
// no dependencies
module vlbs_ram #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/vlbs_serial.sv
// vlbs_serial: byte-serial result unit, emits streamed bytes or folds them
// into a byte or int answer; holds the result register. uses vlbs_pkg
module vlbs_serial import vlbs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  vlbs_beat_t       beat,
	input  logic [7:0]       rd_byte,
	input  logic [LEN_W-1:0] entry_len,
	input  logic             dir_valid,
	input  vlbs_out_t        dir,
	output vlbs_out_t        result,
	output logic             result_strobe
);

	logic [7:0]  b;
	logic        take;
	logic        nz_q;
	logic        bad_q;
	logic [2:0]  cnt_q;
	logic [2:0]  cnt_nx;
	logic [23:0] val_q;
	logic [23:0] val_nx;
	logic        res_v;
	vlbs_out_t   res_c;

	always_comb begin
		b      = beat.pad ? 8'd0 : rd_byte;
		take   = nz_q || (b != 8'd0) || beat.last;
		cnt_nx = (cnt_q == 3'd4) ? cnt_q : cnt_q + 3'd1;
		val_nx = {val_q[15:0], b};
	end

	always_comb begin
		res_v = 1'b0;
		res_c = '0;
		if (dir_valid) begin
			res_v = 1'b1;
			res_c = dir;
		end else if (beat.valid) begin
			case (beat.cmd)
				CMD_POP, CMD_PEEK: begin
					res_v          = 1'b1;
					res_c.status   = STATUS_OK;
					res_c.out_byte = b;
					res_c.entry_len = entry_len;
					res_c.last_out = beat.last;
				end
				CMD_POP_BYTE: begin
					if (beat.last) begin
						res_v           = 1'b1;
						res_c.entry_len = entry_len;
						res_c.last_out  = 1'b1;
						if (bad_q) begin
							res_c.status = STATUS_NOT_BYTE;
						end else begin
							res_c.status   = STATUS_OK;
							res_c.out_byte = b;
						end
					end
				end
				CMD_POP_INT: begin
					if (beat.last) begin
						res_v           = 1'b1;
						res_c.status    = STATUS_OK;
						res_c.entry_len = entry_len;
						res_c.last_out  = 1'b1;
						res_c.int_value = (cnt_nx > 3'd3) ? SAT_INT : INT_W'(val_nx);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
			nz_q          <= 1'b0;
			bad_q         <= 1'b0;
			cnt_q         <= '0;
		end else begin
			result_strobe <= res_v;
			if (!beat.valid) begin
				nz_q  <= 1'b0;
				bad_q <= 1'b0;
				cnt_q <= '0;
			end else begin
				if (!beat.last && (b != 8'd0)) begin
					bad_q <= 1'b1;
				end
				if (take) begin
					nz_q  <= 1'b1;
					cnt_q <= cnt_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!beat.valid) begin
			val_q <= '0;
		end else if (take) begin
			val_q <= val_nx;
		end
		if (res_v) begin
			result <= res_c;
		end
	end

endmodule

FILE: rtl/vlbs_checker.sv
// vlbs_checker: port-level assertions for the byte stack top level
// uses vlbs_pkg; bound to variable_length_byte_stack_unit below
module vlbs_checker import vlbs_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input vlbs_in_t  item,
	input logic      busy,
	input vlbs_out_t result,
	input logic      result_strobe
);

	// staging a byte never answers
	a_push_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (item.cmd == CMD_PUSH) && !item.last |=> !result_strobe)
		else $error("push without last produced a transaction");

	// a commit is answered with a closing transaction
	a_commit_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (item.cmd == CMD_PUSH) && item.last |->
		##2 (result_strobe && result.last_out))
		else $error("commit transaction missing");

	// empty or overflow answers carry nothing else
	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && (result.status == STATUS_EMPTY) |->
		(result.entry_len == '0) && (result.out_byte == 8'd0) &&
		(result.int_value == '0) && result.last_out)
		else $error("empty status with payload");

	// not-a-byte answer is a single closing transaction without a byte
	a_not_byte: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && (result.status == STATUS_NOT_BYTE) |->
		(result.out_byte == 8'd0) && (result.int_value == '0) && result.last_out)
		else $error("not-a-byte status with payload");

	// an int value only comes with an ok status and a stored entry
	a_int_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && (result.int_value != '0) |->
		(result.status == STATUS_OK) && (result.entry_len != '0) &&
		(result.out_byte == 8'd0))
		else $error("int value on wrong transaction");

endmodule

bind variable_length_byte_stack_unit vlbs_checker u_vlbs_checker (.*);

FILE: tb/variable_length_byte_stack_unit_tb.sv
`timescale 1ns / 100ps
// variable_length_byte_stack_unit_tb: self-checking bench for the byte stack top level
// keeps its own image of the stack, predicts every result and checks it on the strobe
// depends on vlbs_pkg and variable_length_byte_stack_unit
module variable_length_byte_stack_unit_tb import vlbs_pkg::*; ();

	localparam int unsigned STORE_BYTES     = STORE_BYTES_DEF;
	localparam int unsigned MAX_ENTRY_BYTES = MAX_ENTRY_BYTES_DEF;
	localparam int unsigned MAX_ENTRIES     = MAX_ENTRIES_DEF;
	localparam int unsigned RANDOM_ITEMS    = 80;
	localparam int unsigned CALM_ITEMS      = 25;
	localparam int unsigned CYCLE_LIMIT     = 200000;
	localparam int unsigned TAIL_CYCLES     = 40;
	localparam int unsigned PRINT_CAP       = 50;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	vlbs_in_t  item = '0;
	logic      busy;
	vlbs_out_t result;
	logic      result_strobe;

	logic [7:0]  store_image [STORE_BYTES];
	int unsigned fill_ptr = 0;
	int unsigned entry_cnt = 0;
	int unsigned staged_cnt = 0;
	vlbs_out_t   due_results [$];
	vlbs_out_t   want_result;

	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned item_count = 0;
	bit          idle_on = 1'b1;

	variable_length_byte_stack_unit dut (
		.clk,
		.arst_n,
		.start,
		.item,
		.busy,
		.result,
		.result_strobe
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				due_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		if (error_count < PRINT_CAP)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			if (due_results.size() == 0) begin
				report_mismatch("result with no transaction pending");
			end else begin
				want_result = due_results.pop_front();
				check_field("status", 32'(result.status), 32'(want_result.status));
				check_field("out_byte", 32'(result.out_byte), 32'(want_result.out_byte));
				check_field("entry_len", 32'(result.entry_len), 32'(want_result.entry_len));
				check_field("int_value", 32'(result.int_value), 32'(want_result.int_value));
				check_field("last_out", 32'(result.last_out), 32'(want_result.last_out));
			end
		end
	end

	function automatic logic [7:0] stored_byte(input int unsigned idx);
		return (idx < STORE_BYTES) ? store_image[idx] : 8'h00;
	endfunction

	function automatic void queue_result(input logic [1:0] st, input logic [7:0] b,
		input int unsigned len, input logic [INT_W-1:0] iv, input logic fin);
		vlbs_out_t r;
		r.status    = st;
		r.out_byte  = b;
		r.entry_len = LEN_W'(len);
		r.int_value = iv;
		r.last_out  = fin;
		due_results.push_back(r);
	endfunction

	task automatic apply_stack_op(input vlbs_in_t op);
		int unsigned len, ptr, base, req, k, s, n, v;
		logic [7:0] b;
		bit bad;
		if (op.cmd == CMD_PUSH) begin
			if (staged_cnt < MAX_ENTRY_BYTES && fill_ptr + staged_cnt < STORE_BYTES)
				store_image[fill_ptr + staged_cnt] = op.data_byte;
			if (staged_cnt <= MAX_ENTRY_BYTES)
				staged_cnt++;
			if (op.last) begin
				len = staged_cnt;
				staged_cnt = 0;
				if (len > MAX_ENTRY_BYTES || entry_cnt >= MAX_ENTRIES ||
					fill_ptr + len + 1 > STORE_BYTES) begin
					queue_result(STATUS_EMPTY, 8'h00, 0, '0, 1'b1);
				end else begin
					store_image[fill_ptr + len] = 8'(len);
					fill_ptr += len + 1;
					entry_cnt++;
					queue_result(STATUS_OK, 8'h00, len, '0, 1'b1);
				end
			end
		end else if (op.cmd <= CMD_POP_INT) begin
			staged_cnt = 0;
			if (op.cmd == CMD_PEEK) begin
				if (op.depth < 1 || op.depth > entry_cnt) begin
					queue_result(STATUS_EMPTY, 8'h00, 0, '0, 1'b1);
				end else begin
					ptr = fill_ptr;
					len = 0;
					for (k = 0; k < op.depth; k++) begin
						len = (ptr > 0) ? stored_byte(ptr - 1) : 0;
						ptr = (ptr >= len + 1) ? ptr - len - 1 : 0;
					end
					if (len > MAX_ENTRY_BYTES)
						len = MAX_ENTRY_BYTES;
					if (len == 0)
						queue_result(STATUS_OK, 8'h00, 0, '0, 1'b1);
					else
						for (k = 0; k < len; k++)
							queue_result(STATUS_OK, stored_byte(ptr + k), len, '0, k + 1 == len);
				end
			end else if (entry_cnt == 0) begin
				queue_result(STATUS_EMPTY, 8'h00, 0, '0, 1'b1);
			end else begin
				len = (fill_ptr > 0) ? stored_byte(fill_ptr - 1) : 0;
				base = (fill_ptr >= len + 1) ? fill_ptr - len - 1 : 0;
				fill_ptr = base;
				entry_cnt--;
				if (op.cmd == CMD_POP) begin
					req = (op.req_len > MAX_ENTRY_BYTES) ? MAX_ENTRY_BYTES : op.req_len;
					if (req == 0) begin
						queue_result(STATUS_OK, 8'h00, len, '0, 1'b1);
					end else begin
						for (k = 0; k < req; k++) begin
							if (len >= req)
								b = stored_byte(base + len - req + k);
							else if (k < req - len)
								b = 8'h00;
							else
								b = stored_byte(base + k - (req - len));
							queue_result(STATUS_OK, b, len, '0, k + 1 == req);
						end
					end
				end else if (op.cmd == CMD_POP_BYTE) begin
					bad = (len == 0);
					for (k = 0; !bad && k + 1 < len; k++)
						if (stored_byte(base + k) != 8'h00)
							bad = 1'b1;
					if (bad)
						queue_result(STATUS_NOT_BYTE, 8'h00, len, '0, 1'b1);
					else
						queue_result(STATUS_OK, stored_byte(base + len - 1), len, '0, 1'b1);
				end else begin
					s = base;
					n = len;
					v = 0;
					while (n > 1 && stored_byte(s) == 8'h00) begin
						s++;
						n--;
					end
					if (n > 3)
						v = SAT_INT;
					else
						for (k = 0; k < n; k++)
							v = (v << 8) | stored_byte(s + k);
					queue_result(STATUS_OK, 8'h00, len, INT_W'(v), 1'b1);
				end
			end
		end
	endtask

	task automatic send_op(input logic [CMD_W-1:0] cmd, input logic [7:0] data,
		input logic fin, input logic [LEN_W-1:0] req, input logic [DEPTH_W-1:0] dep);
		vlbs_in_t op;
		op.cmd       = cmd;
		op.data_byte = data;
		op.last      = fin;
		op.req_len   = req;
		op.depth     = dep;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		item <= op;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		apply_stack_op(op);
		if (cmd <= CMD_POP_INT)
			item_count++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0);
	endtask

	task automatic push_bytes(input logic [7:0] bytes [$]);
		int unsigned k;
		for (k = 0; k < bytes.size(); k++)
			send_op(CMD_PUSH, bytes[k], k + 1 == bytes.size(), LEN_W'($urandom),
				DEPTH_W'($urandom));
	endtask

	task automatic push_random_entry(input int unsigned len);
		logic [7:0] bytes [$];
		int unsigned lead, k;
		lead = $urandom_range(0, len);
		for (k = 0; k < len; k++)
			bytes.push_back((k < lead && $urandom_range(0, 3) != 0) ? 8'h00 : 8'($urandom));
		push_bytes(bytes);
	endtask

	task automatic pop_any();
		int unsigned roll;
		roll = $urandom_range(0, 2);
		if (roll == 0)
			send_op(CMD_POP, 8'($urandom), 1'($urandom), LEN_W'($urandom_range(0, 63)),
				DEPTH_W'($urandom));
		else if (roll == 1)
			send_op(CMD_POP_BYTE, 8'($urandom), 1'($urandom), LEN_W'($urandom),
				DEPTH_W'($urandom));
		else
			send_op(CMD_POP_INT, 8'($urandom), 1'($urandom), LEN_W'($urandom),
				DEPTH_W'($urandom));
	endtask

	task automatic peek_any();
		int unsigned dep;
		if (entry_cnt > 0 && $urandom_range(0, 4) != 0)
			dep = $urandom_range(1, entry_cnt);
		else if ($urandom_range(0, 1) == 0)
			dep = entry_cnt + 1;
		else
			dep = $urandom_range(0, 2047);
		send_op(CMD_PEEK, 8'($urandom), 1'($urandom), LEN_W'($urandom), DEPTH_W'(dep));
	endtask

	task automatic empty_stack();
		while (entry_cnt > 0)
			pop_any();
	endtask

	task automatic test_empty_stack();
		send_op(CMD_POP, 8'h00, 1'b0, 6'd5, 11'd0);
		send_op(CMD_POP_BYTE, 8'hFF, 1'b1, 6'd63, 11'd2047);
		send_op(CMD_POP_INT, 8'h00, 1'b0, 6'd0, 11'd1);
		send_op(CMD_PEEK, 8'h00, 1'b0, 6'd0, 11'd1);
		send_op(CMD_PEEK, 8'h00, 1'b0, 6'd0, 11'd0);
		wait_drained();
	endtask

	task automatic test_pop_kinds();
		logic [7:0] ones [$];
		int unsigned k;
		for (k = 0; k < MAX_ENTRY_BYTES; k++)
			ones.push_back(8'hFF);
		push_bytes(ones);
		send_op(CMD_POP, 8'h00, 1'b0, 6'd32, 11'd0);
		push_bytes('{8'h00, 8'h00, 8'hAB, 8'hCD, 8'hEF});
		send_op(CMD_POP_INT, 8'h00, 1'b0, 6'd0, 11'd0);
		push_bytes('{8'h01, 8'h02, 8'h03, 8'h04});
		send_op(CMD_POP_INT, 8'h00, 1'b0, 6'd0, 11'd0);
		push_bytes('{8'h00});
		send_op(CMD_POP_INT, 8'h00, 1'b0, 6'd0, 11'd0);
		push_bytes('{8'h00, 8'h00, 8'h07});
		send_op(CMD_POP_BYTE, 8'h00, 1'b0, 6'd0, 11'd0);
		push_bytes('{8'h01, 8'h05});
		send_op(CMD_POP_BYTE, 8'h00, 1'b0, 6'd0, 11'd0);
		push_bytes('{8'h12, 8'h34});
		send_op(CMD_POP, 8'h00, 1'b0, 6'd0, 11'd0);
		push_bytes('{8'h12, 8'h34});
		send_op(CMD_POP, 8'h00, 1'b0, 6'd63, 11'd0);
		push_random_entry(MAX_ENTRY_BYTES);
		send_op(CMD_POP, 8'h00, 1'b0, 6'd1, 11'd0);
		wait_drained();
	endtask

	task automatic test_peek();
		push_bytes('{8'h80});
		push_random_entry(MAX_ENTRY_BYTES);
		push_bytes('{8'h3C, 8'hC3});
		send_op(CMD_PEEK, 8'h00, 1'b0, 6'd0, 11'd1);
		send_op(CMD_PEEK, 8'h00, 1'b0, 6'd0, 11'd2);
		send_op(CMD_PEEK, 8'h00, 1'b0, 6'd0, 11'd3);
		send_op(CMD_PEEK, 8'h00, 1'b0, 6'd0, 11'd4);
		send_op(CMD_PEEK, 8'h00, 1'b0, 6'd0, 11'd0);
		send_op(CMD_PEEK, 8'h00, 1'b0, 6'd0, '1);
		empty_stack();
		wait_drained();
	endtask

	task automatic test_push_limits();
		int unsigned k;
		send_op(CMD_PUSH, 8'hAA, 1'b0, 6'd0, 11'd0);
		send_op(CMD_PUSH, 8'h55, 1'b0, 6'd0, 11'd0);
		send_op(CMD_POP_INT, 8'h00, 1'b0, 6'd0, 11'd0);
		push_bytes('{8'h5A});
		send_op(CMD_PUSH, 8'h11, 1'b0, 6'd0, 11'd0);
		send_op(CMD_PUSH, 8'h22, 1'b0, 6'd0, 11'd0);
		send_op(CMD_POP_INT + CMD_W'(1), 8'h00, 1'b0, 6'd0, 11'd0);
		send_op(CMD_PUSH, 8'h33, 1'b1, 6'd0, 11'd0);
		send_op(CMD_POP, 8'h00, 1'b0, 6'd3, 11'd0);
		for (k = 0; k < MAX_ENTRY_BYTES + 2; k++)
			send_op(CMD_PUSH, 8'($urandom), k == MAX_ENTRY_BYTES + 1, 6'd0, 11'd0);
		empty_stack();
		wait_drained();
	endtask

	task automatic test_random_mix();
		int unsigned roll, first, len, k;
		first = item_count;
		while (item_count - first < RANDOM_ITEMS) begin
			if (item_count - first > RANDOM_ITEMS - CALM_ITEMS)
				idle_on = 1'b0;
			roll = $urandom_range(0, 99);
			if (roll < 36 && entry_cnt < 48) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, MAX_ENTRY_BYTES)
					: $urandom_range(1, 4);
				push_random_entry(len);
			end else if (roll < 64) begin
				pop_any();
			end else if (roll < 76) begin
				peek_any();
			end else if (roll < 82) begin
				for (k = $urandom_range(1, 3); k > 0; k--)
					send_op(CMD_PUSH, 8'($urandom), 1'b0, LEN_W'($urandom), DEPTH_W'($urandom));
			end else if (roll < 86) begin
				send_op(CMD_POP_INT + CMD_W'($urandom_range(1, 3)), 8'($urandom),
					1'($urandom), LEN_W'($urandom), DEPTH_W'($urandom));
			end else if (roll < 88) begin
				wait_drained();
			end else if (roll < 90) begin
				push_random_entry($urandom_range(MAX_ENTRY_BYTES + 1, MAX_ENTRY_BYTES + 3));
			end else begin
				pop_any();
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_stack();
		test_pop_kinds();
		test_peek();
		test_push_limits();
		test_random_mix();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
